FILE: src/ebi_pkg.sv
// package for the 2d euler body integrator
// holds fixed-point constants, cordic tables and datapath command types
// no dependencies

package ebi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;
    localparam int TRIG_ONE     = 30;
    localparam int STEP_W       = 5;
    localparam int DIV_SH       = TRIG_ONE - FRAC_BITS;

    localparam logic signed [33:0] GAIN_INV   = 34'sd652032874;
    localparam logic [31:0]        PI_Q_Q30   = 32'd843314856;
    localparam logic [31:0]        MASS_RESET = 32'd65536;

    // pi/4 split into whole multiples of 4500 and the remainder
    localparam logic [31:0] PI_Q_DIV   = PI_Q_Q30 / 32'd4500;
    localparam logic [23:0] PI_Q_REM   = 24'(PI_Q_Q30 % 32'd4500);
    // reciprocal of 4500 rounded up, exact for dividends below 2^24
    localparam int          RECIP_SH   = 37;
    localparam logic [24:0] RECIP_4500 =
        25'(((64'd1 << RECIP_SH) + 64'd4499) / 64'd4500);

    localparam logic [1:0] REG_MASS    = 2'd0;
    localparam logic [1:0] REG_START_X = 2'd1;
    localparam logic [1:0] REG_START_Y = 2'd2;

    localparam logic MODE_FORCE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // datapath operation codes
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_SCALE,
        OP_CORDIC,
        OP_QUAD,
        OP_DIV_X_START,
        OP_DIV_STEP,
        OP_ACC_X,
        OP_DIV_Y_START,
        OP_ACC_Y,
        OP_VEL,
        OP_POS
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic mode;
    } dp_stat_t;

    function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sh3243F6A8;
            5'd1:  v = 34'sh1DAC6705;
            5'd2:  v = 34'sh0FADBAFC;
            5'd3:  v = 34'sh07F56EA6;
            5'd4:  v = 34'sh03FEAB76;
            5'd5:  v = 34'sh01FFD55B;
            5'd6:  v = 34'sh00FFFAAA;
            5'd7:  v = 34'sh007FFF55;
            5'd8:  v = 34'sh003FFFEA;
            5'd9:  v = 34'sh001FFFFD;
            5'd10: v = 34'sh000FFFFF;
            5'd11: v = 34'sh0007FFFF;
            5'd12: v = 34'sh0003FFFF;
            5'd13: v = 34'sh0001FFFF;
            5'd14: v = 34'sh0000FFFF;
            5'd15: v = 34'sh00007FFF;
            5'd16: v = 34'sh00003FFF;
            5'd17: v = 34'sh00001FFF;
            5'd18: v = 34'sh00000FFF;
            5'd19: v = 34'sh000007FF;
            5'd20: v = 34'sh000003FF;
            5'd21: v = 34'sh000001FF;
            5'd22: v = 34'sh000000FF;
            5'd23: v = 34'sh0000007F;
            5'd24: v = 34'sh0000003F;
            5'd25: v = 34'sh0000001F;
            5'd26: v = 34'sh0000000F;
            5'd27: v = 34'sh00000007;
            5'd28: v = 34'sh00000003;
            5'd29: v = 34'sh00000001;
            default: v = 34'sh0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/ebi_datapath.sv
// datapath of the 2d euler body integrator: state, cordic, divider, tick math
// depends on ebi_pkg

module ebi_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  ebi_pkg::dp_cmd_t    cmd,
    output ebi_pkg::dp_stat_t   stat,
    input  logic                in_mode,
    input  logic [31:0]         in_mag,
    input  logic [15:0]         in_angle,
    input  logic [15:0]         in_dt,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic [31:0]         pos_x,
    output logic [31:0]         pos_y,
    output logic [31:0]         vel_x,
    output logic [31:0]         vel_y,
    output logic [31:0]         acc_x,
    output logic [31:0]         acc_y,
    output logic                sat_flag
);

    // architectural state
    logic [31:0] mass_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, ax_reg, ay_reg;
    logic sat_reg;

    // item latch
    logic        mode_reg;
    logic [31:0] mag_reg;
    logic [15:0] ang_reg, dt_reg;

    // angle reduction and cordic
    logic [1:0]  quad_reg;
    logic [13:0] rem_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic signed [33:0] cos_reg, sin_reg;

    // divider
    logic [63:0] prod_reg;      // magnitude * |trig|
    logic [64:0] rmd_reg;
    logic [63:0] quo_reg;
    logic        neg_reg;
    logic [6:0]  dcnt_reg;

    // angle reduction helpers (angle below 65536 so at most one subtract of 36000)
    logic [15:0] a_mod;
    logic [1:0]  q_c;
    logic [13:0] r_c;
    always_comb begin
        a_mod = (ang_reg >= 16'd36000) ? ang_reg - 16'd36000 : ang_reg;
        if (a_mod >= 16'd27000) begin
            q_c = 2'd3; r_c = 14'(a_mod - 16'd27000);
        end else if (a_mod >= 16'd18000) begin
            q_c = 2'd2; r_c = 14'(a_mod - 16'd18000);
        end else if (a_mod >= 16'd9000) begin
            q_c = 2'd1; r_c = 14'(a_mod - 16'd9000);
        end else begin
            q_c = 2'd0; r_c = 14'(a_mod);
        end
    end

    // radians in q2.30: round(r*p/4500) as r*(p div 4500) plus the small
    // leftover (r*(p mod 4500)+2250)/4500 taken by a reciprocal multiply
    logic [31:0] z_int;
    logic [23:0] z_low;
    logic [48:0] z_recip;
    logic [31:0] z_c;
    always_comb begin
        z_int   = 32'(rem_reg) * ebi_pkg::PI_Q_DIV;
        z_low   = 24'(rem_reg) * ebi_pkg::PI_Q_REM + 24'd2250;
        z_recip = 49'(z_low) * 49'(ebi_pkg::RECIP_4500);
        z_c     = z_int + 32'(z_recip >> ebi_pkg::RECIP_SH);
    end

    // cordic step
    logic signed [33:0] dx, dy, at;
    always_comb begin
        dx = cy_reg >>> cmd.step;
        dy = cx_reg >>> cmd.step;
        at = ebi_pkg::atan_q30(cmd.step);
    end

    // divisor and restoring divide step
    logic [31:0] mass_eff;
    logic [63:0] divisor;
    logic [64:0] trial;
    always_comb begin
        mass_eff = (mass_reg == 32'd0) ? 32'd1 : mass_reg;
        divisor  = 64'(mass_eff) << ebi_pkg::DIV_SH;
        trial    = {rmd_reg[63:0], prod_reg[63]} - {1'b0, divisor};
    end

    // trig magnitude for the force terms
    logic signed [33:0] trig_sel;
    logic [33:0] trig_abs;
    always_comb begin
        trig_sel = (cmd.op == ebi_pkg::OP_DIV_Y_START) ? sin_reg : cos_reg;
        trig_abs = trig_sel[33] ? 34'(-trig_sel) : 34'(trig_sel);
    end

    // signed force term from quotient, saturated to 32 bits
    logic signed [63:0] fq;
    logic signed [31:0] fterm;
    logic fsat;
    always_comb begin
        fq = (quo_reg > 64'h3FFFFFFFFFFFFFFF) ? 64'sh3FFFFFFFFFFFFFFF : $signed(quo_reg);
        if (neg_reg) fq = -fq;
        fsat = 1'b0;
        if (fq > 64'sd2147483647) begin
            fterm = 32'sh7FFFFFFF; fsat = 1'b1;
        end else if (fq < -64'sd2147483648) begin
            fterm = 32'sh80000000; fsat = 1'b1;
        end else begin
            fterm = 32'(fq);
        end
    end

    // accumulate with saturation
    logic signed [32:0] acc_sum;
    logic signed [31:0] acc_res;
    logic acc_sat;
    always_comb begin
        if (cmd.op == ebi_pkg::OP_ACC_Y) acc_sum = 33'(ay_reg) - 33'(fterm);
        else                             acc_sum = 33'(ax_reg) + 33'(fterm);
        acc_sat = 1'b0;
        if (acc_sum > 33'sd2147483647) begin
            acc_res = 32'sh7FFFFFFF; acc_sat = 1'b1;
        end else if (acc_sum < -33'sd2147483648) begin
            acc_res = 32'sh80000000; acc_sat = 1'b1;
        end else begin
            acc_res = 32'(acc_sum);
        end
    end

    // tick products: two 32x17 multiplies per step, x and y
    logic signed [31:0] base_x, base_y, mul_x, mul_y;
    logic signed [48:0] prx, pry;
    logic signed [33:0] tsx, tsy;
    logic signed [31:0] tx, ty;
    logic tsat_x, tsat_y;
    always_comb begin
        if (cmd.op == ebi_pkg::OP_POS) begin
            base_x = px_reg; base_y = py_reg; mul_x = vx_reg; mul_y = vy_reg;
        end else begin
            base_x = vx_reg; base_y = vy_reg; mul_x = ax_reg; mul_y = ay_reg;
        end
        prx = 49'(mul_x) * $signed({1'b0, dt_reg});
        pry = 49'(mul_y) * $signed({1'b0, dt_reg});
        tsx = 34'(base_x) + 34'(prx >>> 16);
        tsy = 34'(base_y) + 34'(pry >>> 16);
        tsat_x = 1'b0; tsat_y = 1'b0;
        if (tsx > 34'sd2147483647) begin
            tx = 32'sh7FFFFFFF; tsat_x = 1'b1;
        end else if (tsx < -34'sd2147483648) begin
            tx = 32'sh80000000; tsat_x = 1'b1;
        end else begin
            tx = 32'(tsx);
        end
        if (tsy > 34'sd2147483647) begin
            ty = 32'sh7FFFFFFF; tsat_y = 1'b1;
        end else if (tsy < -34'sd2147483648) begin
            ty = 32'sh80000000; tsat_y = 1'b1;
        end else begin
            ty = 32'(tsy);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg <= ebi_pkg::MASS_RESET;
            px_reg <= '0; py_reg <= '0;
            vx_reg <= '0; vy_reg <= '0;
            ax_reg <= '0; ay_reg <= '0;
            dcnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    ebi_pkg::REG_MASS:    mass_reg <= cfg_data;
                    ebi_pkg::REG_START_X: px_reg <= $signed(cfg_data);
                    ebi_pkg::REG_START_Y: py_reg <= $signed(cfg_data);
                    default: ;
                endcase
            end
            unique case (cmd.op)
                ebi_pkg::OP_DIV_X_START, ebi_pkg::OP_DIV_Y_START: dcnt_reg <= 7'd0;
                ebi_pkg::OP_DIV_STEP: dcnt_reg <= dcnt_reg + 7'd1;
                ebi_pkg::OP_ACC_X: ax_reg <= acc_res;
                ebi_pkg::OP_ACC_Y: ay_reg <= acc_res;
                ebi_pkg::OP_VEL: begin vx_reg <= tx; vy_reg <= ty; end
                ebi_pkg::OP_POS: begin px_reg <= tx; py_reg <= ty; end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            ebi_pkg::OP_LOAD: begin
                mode_reg <= in_mode; mag_reg <= in_mag;
                ang_reg <= in_angle; dt_reg <= in_dt;
                sat_reg <= 1'b0;
            end
            ebi_pkg::OP_REDUCE: begin quad_reg <= q_c; rem_reg <= r_c; end
            ebi_pkg::OP_SCALE: begin
                cx_reg <= ebi_pkg::GAIN_INV; cy_reg <= '0; cz_reg <= 34'(z_c);
            end
            ebi_pkg::OP_CORDIC: begin
                if (!cz_reg[33]) begin
                    cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy; cz_reg <= cz_reg - at;
                end else begin
                    cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy; cz_reg <= cz_reg + at;
                end
            end
            ebi_pkg::OP_QUAD: begin
                unique case (quad_reg)
                    2'd0: begin cos_reg <= cx_reg;  sin_reg <= cy_reg;  end
                    2'd1: begin cos_reg <= -cy_reg; sin_reg <= cx_reg;  end
                    2'd2: begin cos_reg <= -cx_reg; sin_reg <= -cy_reg; end
                    default: begin cos_reg <= cy_reg; sin_reg <= -cx_reg; end
                endcase
            end
            ebi_pkg::OP_DIV_X_START, ebi_pkg::OP_DIV_Y_START: begin
                prod_reg <= 64'(mag_reg) * 64'(trig_abs[31:0]);
                neg_reg  <= trig_sel[33];
                rmd_reg  <= '0;
                quo_reg  <= '0;
            end
            ebi_pkg::OP_DIV_STEP: begin
                prod_reg <= {prod_reg[62:0], 1'b0};
                if (!trial[64]) begin
                    rmd_reg <= trial; quo_reg <= {quo_reg[62:0], 1'b1};
                end else begin
                    rmd_reg <= {rmd_reg[63:0], prod_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
            ebi_pkg::OP_ACC_X, ebi_pkg::OP_ACC_Y: sat_reg <= sat_reg | fsat | acc_sat;
            ebi_pkg::OP_VEL, ebi_pkg::OP_POS: sat_reg <= sat_reg | tsat_x | tsat_y;
            default: ;
        endcase
    end

    assign stat.div_done = (dcnt_reg == 7'd63);
    assign stat.mode     = mode_reg;

    assign pos_x = px_reg; assign pos_y = py_reg;
    assign vel_x = vx_reg; assign vel_y = vy_reg;
    assign acc_x = ax_reg; assign acc_y = ay_reg;
    assign sat_flag = sat_reg;

endmodule

FILE: src/ebi_control.sv
// sequencer of the 2d euler body integrator: handshakes and datapath commands
// depends on ebi_pkg

module ebi_control (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ebi_pkg::dp_cmd_t    cmd,
    input  ebi_pkg::dp_stat_t   stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_REDUCE, S_SCALE, S_CORDIC, S_QUAD,
        S_DIVX, S_STEPX, S_ACCX, S_DIVY, S_STEPY, S_ACCY,
        S_VEL, S_POS, S_OUT
    } state_t;

    state_t state_reg;
    logic [ebi_pkg::STEP_W-1:0] step_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);

    // command decode
    always_comb begin
        cmd.step = step_reg;
        unique case (state_reg)
            S_IDLE:   cmd.op = (s_tvalid) ? ebi_pkg::OP_LOAD : ebi_pkg::OP_NONE;
            S_REDUCE: cmd.op = ebi_pkg::OP_REDUCE;
            S_SCALE:  cmd.op = ebi_pkg::OP_SCALE;
            S_CORDIC: cmd.op = ebi_pkg::OP_CORDIC;
            S_QUAD:   cmd.op = ebi_pkg::OP_QUAD;
            S_DIVX:   cmd.op = ebi_pkg::OP_DIV_X_START;
            S_DIVY:   cmd.op = ebi_pkg::OP_DIV_Y_START;
            S_STEPX, S_STEPY: cmd.op = ebi_pkg::OP_DIV_STEP;
            S_ACCX:   cmd.op = ebi_pkg::OP_ACC_X;
            S_ACCY:   cmd.op = ebi_pkg::OP_ACC_Y;
            S_VEL:    cmd.op = ebi_pkg::OP_VEL;
            S_POS:    cmd.op = ebi_pkg::OP_POS;
            default:  cmd.op = ebi_pkg::OP_NONE;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE:     if (s_tvalid) state_reg <= S_DISPATCH;
                S_DISPATCH: state_reg <= (stat.mode == ebi_pkg::MODE_TICK) ? S_VEL : S_REDUCE;
                S_REDUCE:   state_reg <= S_SCALE;
                S_SCALE: begin state_reg <= S_CORDIC; step_reg <= '0; end
                S_CORDIC: begin
                    if (step_reg == ebi_pkg::STEP_W'(ebi_pkg::CORDIC_STEPS - 1))
                        state_reg <= S_QUAD;
                    step_reg <= step_reg + 1'b1;
                end
                S_QUAD:  state_reg <= S_DIVX;
                S_DIVX:  state_reg <= S_STEPX;
                S_STEPX: if (stat.div_done) state_reg <= S_ACCX;
                S_ACCX:  state_reg <= S_DIVY;
                S_DIVY:  state_reg <= S_STEPY;
                S_STEPY: if (stat.div_done) state_reg <= S_ACCY;
                S_ACCY:  state_reg <= S_OUT;
                S_VEL:   state_reg <= S_POS;
                S_POS:   state_reg <= S_OUT;
                S_OUT:   if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result is offered only after the last step of an item (acc_y or pos)
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_ACCY || $past(state_reg) == S_POS)
        else $error("result raised without finishing an item");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");
    a_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped without handshake");

endmodule

FILE: src/euler_body_integrator_2d_unit.sv
// top level of the 2d euler body integrator
// depends on ebi_pkg, ebi_control, ebi_datapath
//
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   s_tdata, s_tuser (mode)
// m_       out  m_tvalid/m_tready   m_tdata, m_tuser (saturated)
// cfg      in   cfg_we              cfg_index, cfg_data
//
// tick word: dispatch, then velocity and position updates; force word: dispatch,
// reduction, scaling, the 16-step cordic and two 64-step serial divides by mass.
// one word at a time; a new word is taken the cycle after the result is taken.
// synchronous active-low reset clears position, velocity and acceleration and loads unit mass.
// m_tdata holds while m_tready is low, unless cfg_we writes a start position.

module euler_body_integrator_2d_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // force_magnitude[31:0], force_angle[47:32], time_step[63:48]
    input  logic         s_tuser,   // mode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y (32 each)
    output logic         m_tuser,   // saturated
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    ebi_pkg::dp_cmd_t  cmd;
    ebi_pkg::dp_stat_t stat;

    ebi_control u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd, .stat
    );

    ebi_datapath u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_mode(s_tuser), .in_mag(s_tdata[31:0]),
        .in_angle(s_tdata[47:32]), .in_dt(s_tdata[63:48]),
        .cfg_we, .cfg_index, .cfg_data,
        .pos_x(m_tdata[31:0]), .pos_y(m_tdata[63:32]),
        .vel_x(m_tdata[95:64]), .vel_y(m_tdata[127:96]),
        .acc_x(m_tdata[159:128]), .acc_y(m_tdata[191:160]),
        .sat_flag(m_tuser)
    );

endmodule
